// ===== design/uline_pkg.sv =====
package uline_pkg;

   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_ENTER = 2'd1,
      KIND_BACK  = 2'd2,
      KIND_FUNC  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_IGNORED = 2'd0,
      STAT_TAKEN   = 2'd1,
      STAT_LINE    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_BK_RD,
      ST_BK_CHK,
      ST_BK_FIN,
      ST_SUB_RD,
      ST_SUB_DATA
   } state_type;

   localparam logic [7:0] KEY_LF      = 8'd10;
   localparam logic [7:0] KEY_CR      = 8'd13;
   localparam logic [7:0] KEY_DEL     = 8'd127;
   localparam logic [7:0] KEY_SPACE   = 8'd32;
   localparam logic [7:0] KEY_TILDE   = 8'd126;
   localparam logic [7:0] CONT_LOW    = 8'h80;
   localparam logic [7:0] CONT_HIGH   = 8'hBF;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] LEAD2_LOW   = 8'hC2;
   localparam logic [7:0] LEAD3_LOW   = 8'hE0;
   localparam logic [7:0] LEAD4_LOW   = 8'hF0;
   localparam logic [7:0] LEAD_END    = 8'hF8;

   // Number of continuation bytes a lead byte announces; zero for no valid lead.
   function automatic logic [1:0] cont_needed(input logic [7:0] b);
      logic [1:0] n;
      n = 2'd0;
      if (b >= LEAD2_LOW && b < LEAD3_LOW) begin
         n = 2'd1;
      end else if (b >= LEAD3_LOW && b < LEAD4_LOW) begin
         n = 2'd2;
      end else if (b >= LEAD4_LOW && b < LEAD_END) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

// ===== design/utf8_line_input_buffer_top.sv =====
// Line editor fed one key event per word. Printable ASCII and complete UTF-8 sequences are
// stored in a single-port-read RAM of LINE_BYTES-1 bytes; a sequence that would not fit is
// dropped whole. Enter returns the line one byte per word with tlast on the final byte (or one
// empty-line word) and clears it; backspace removes the last code point. A new key is taken
// whenever the editor is idle, even while a result still waits in the output register. A
// backspace reads the line RAM back from the end, once per byte looked at, until it finds the
// start of the last character; an enter reads it once per line byte. Any step that loads a
// result waits while the output register is full and its result is not being taken.
// No clearing pass runs after reset.
module utf8_line_input_buffer_top
   import uline_pkg::*;
   #(parameter int LINE_BYTES = 64)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_tvalid,
    output logic        req_tready,
    input  logic [7:0]  req_tdata,   // key_byte
    input  logic [1:0]  req_tuser,   // special_key
    output logic        rsp_tvalid,
    input  logic        rsp_tready,
    output logic [23:0] rsp_tdata,   // line_byte, line_length, char_count, zero padding
    output logic [2:0]  rsp_tuser,   // status, line_empty
    output logic        rsp_tlast);  // last_of_line

   localparam int DEPTH = LINE_BYTES - 1;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [LEN_W:0] LIMIT = (LEN_W + 1)'(LINE_BYTES - 1);

   state_type          state_ff, state_in;
   logic [7:0]         key_ff;
   kind_type           kind_ff;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [LEN_W-1:0]   points_ff, points_in;
   logic [2:0]         pend_ff, pend_in;
   logic [1:0]         need_ff, need_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0]   rsp_pts_ff, rsp_pts_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [7:0]         rd_data;

   logic               out_free;
   logic               load;
   logic               is_enter;
   logic               is_back;
   logic               is_cont;
   logic [LEN_W:0]     seq_addr;
   logic [2:0]         pend_next;
   logic [1:0]         lead_need;

   uline_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign is_enter   = (kind_ff == KIND_ENTER) ||
                       (kind_ff == KIND_BYTE && (key_ff == KEY_LF || key_ff == KEY_CR));
   assign is_back    = (kind_ff == KIND_BACK) || (kind_ff == KIND_BYTE && key_ff == KEY_DEL);
   assign is_cont    = (kind_ff == KIND_BYTE) && key_ff >= CONT_LOW && key_ff <= CONT_HIGH;
   assign seq_addr   = {1'b0, length_ff} + (LEN_W + 1)'(pend_ff);
   assign pend_next  = pend_ff + 3'd1;
   assign lead_need  = cont_needed(key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         points_ff    <= '0;
         pend_ff      <= '0;
         need_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         points_ff    <= points_in;
         pend_ff      <= pend_in;
         need_ff      <= need_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         key_ff  <= req_tdata;
         kind_ff <= kind_type'(req_tuser);
      end
      idx_ff <= idx_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_pts_ff    <= rsp_pts_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      points_in     = points_ff;
      pend_in       = pend_ff;
      need_in       = need_ff;
      idx_in        = idx_ff;
      load          = 1'b0;
      rsp_status_in = STAT_TAKEN;
      rsp_byte_in   = '0;
      rsp_empty_in  = 1'b0;
      rsp_last_in   = 1'b1;
      rsp_len_in    = length_ff;
      rsp_pts_in    = points_ff;
      wr_en         = 1'b0;
      wr_addr       = seq_addr[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (is_enter) begin
                  pend_in = '0;
                  need_in = '0;
                  if (length_ff == '0) begin
                     load          = 1'b1;
                     rsp_status_in = STAT_LINE;
                     rsp_empty_in  = 1'b1;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_SUB_RD;
                  end
               end else if (is_back) begin
                  pend_in = '0;
                  need_in = '0;
                  if (length_ff == '0) begin
                     load = 1'b1;
                  end else begin
                     idx_in   = length_ff - 1'b1;
                     state_in = ST_BK_RD;
                  end
               end else if (need_ff != '0 && is_cont) begin
                  load    = 1'b1;
                  wr_en   = (seq_addr < LIMIT);
                  pend_in = pend_next;
                  need_in = need_ff - 2'd1;
                  if (need_ff == 2'd1) begin
                     pend_in = '0;
                     if (({1'b0, length_ff} + (LEN_W + 1)'(pend_next)) <= LIMIT) begin
                        length_in = length_ff + LEN_W'(pend_next);
                        points_in = points_ff + 1'b1;
                     end
                  end
                  rsp_len_in = length_in;
                  rsp_pts_in = points_in;
               end else begin
                  load    = 1'b1;
                  pend_in = '0;
                  need_in = '0;
                  wr_addr = length_ff[AW-1:0];
                  if (kind_ff == KIND_BYTE && key_ff >= CONT_LOW) begin
                     if (lead_need != '0) begin
                        wr_en   = ({1'b0, length_ff} < LIMIT);
                        pend_in = 3'd1;
                        need_in = lead_need;
                     end else begin
                        rsp_status_in = STAT_IGNORED;
                     end
                  end else if (kind_ff == KIND_BYTE && key_ff >= KEY_SPACE &&
                               key_ff <= KEY_TILDE && {1'b0, length_ff} < LIMIT) begin
                     wr_en      = 1'b1;
                     length_in  = length_ff + 1'b1;
                     points_in  = points_ff + 1'b1;
                     rsp_len_in = length_in;
                     rsp_pts_in = points_in;
                  end else begin
                     rsp_status_in = STAT_IGNORED;
                  end
               end
            end
         end
         ST_BK_RD: begin
            if (idx_ff == '0) begin
               state_in = ST_BK_FIN;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_BK_CHK;
            end
         end
         ST_BK_CHK: begin
            if ((rd_data & CONT_MASK) == CONT_LOW) begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_BK_RD;
            end else begin
               state_in = ST_BK_FIN;
            end
         end
         ST_BK_FIN: begin
            if (out_free) begin
               load      = 1'b1;
               length_in = idx_ff;
               if (points_ff != '0) begin
                  points_in = points_ff - 1'b1;
               end
               rsp_len_in = length_in;
               rsp_pts_in = points_in;
               state_in   = ST_IDLE;
            end
         end
         ST_SUB_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SUB_DATA;
         end
         ST_SUB_DATA: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = STAT_LINE;
               rsp_byte_in   = rd_data;
               rsp_len_in    = '0;
               rsp_pts_in    = '0;
               rsp_last_in   = (idx_ff + 1'b1 == length_ff);
               if (rsp_last_in) begin
                  length_in = '0;
                  points_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SUB_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_pts_ff, rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_empty_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/uline_ram.sv =====
module uline_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 63)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/uline_checker.sv =====
module uline_checker
   import uline_pkg::*;
   (input logic        clock,
    input logic        reset,
    input logic        rsp_tvalid,
    input logic        rsp_tready,
    input logic [23:0] rsp_tdata,
    input logic [2:0]  rsp_tuser,
    input logic        rsp_tlast);

   // Only a submitted line can produce more than one word per key.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] != STAT_LINE |-> rsp_tlast)
      else $error("edit result without tlast");

   // An empty submission is a single submitted word with a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         rsp_tuser[1:0] == STAT_LINE && rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("malformed empty-line word");

   // Submitted bytes report the line as already cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == STAT_LINE |-> rsp_tdata[19:8] == 12'd0)
      else $error("submitted word reports a non-empty line");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under back-pressure");

endmodule

bind utf8_line_input_buffer_top uline_checker u_uline_checker (.*);

// ===== tb/utf8_line_input_buffer_top_test.sv =====
module utf8_line_input_buffer_top_test;
   import uline_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_BYTES   = 64;
   localparam int KEY_TARGET   = 255;
   localparam int TAIL_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] key;
   } key_word_type;

   typedef struct {
      status_type status;
      logic [7:0] line_char;
      logic       empty_flag;
      logic       last_flag;
      logic [5:0] len;
      logic [5:0] pts;
   } result_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // key_byte
   logic [1:0]  req_tuser  = 2'd0;   // special_key
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // line_byte, line_length, char_count, zero padding
   logic [2:0]  rsp_tuser;           // status, line_empty
   logic        rsp_tlast;

   key_word_type     key_queue[$];
   result_word_type  awaited_words[$];
   key_word_type     next_key;
   result_word_type  got_word;

   logic [7:0]  line_mem [0:LINE_BYTES-2];
   logic [7:0]  seq_bytes [0:3];
   int unsigned line_len, line_pts, seq_count, cont_left;

   int unsigned errors, checked, keys_sent, keys_driven, lines_done, longest_line;
   int unsigned dropped_seqs, full_rejects, cycles;
   int unsigned send_gap, hold_left, calm_left;

   utf8_line_input_buffer_top #(.LINE_BYTES(LINE_BYTES)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast));

   always begin
      #4 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r, g;
      r = $urandom_range(0, 99);
      g = 0;
      if (calm_left > 0) begin
         calm_left--;
      end else if (r < 4) begin
         calm_left = $urandom_range(20, 60);
      end else if (r < 55) begin
         g = 0;
      end else if (r < 90) begin
         g = $urandom_range(1, 3);
      end else begin
         g = $urandom_range(8, 40);
      end
      return g;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("MISMATCH at result word %0d, %s: got %0d, expected %0d",
                  checked, what, got, want);
      end
   endtask

   task automatic note(input status_type s, input logic [7:0] c, input logic e, input logic l);
      result_word_type r;
      r.status     = s;
      r.line_char  = c;
      r.empty_flag = e;
      r.last_flag  = l;
      r.len        = 6'(line_len);
      r.pts        = 6'(line_pts);
      awaited_words.push_back(r);
   endtask

   task automatic edit_line(input key_word_type w);
      logic        plain, is_enter, is_back, done;
      int unsigned i, n, total;
      plain    = (w.kind == KIND_BYTE);
      is_enter = (w.kind == KIND_ENTER) || (plain && (w.key == KEY_LF || w.key == KEY_CR));
      is_back  = (w.kind == KIND_BACK) || (plain && w.key == KEY_DEL);
      done     = 1'b0;
      if (is_enter) begin
         n = line_len;
         seq_count = 0;
         cont_left = 0;
         line_len  = 0;
         line_pts  = 0;
         lines_done++;
         if (n > longest_line) longest_line = n;
         if (n == 0) begin
            note(STAT_LINE, 8'd0, 1'b1, 1'b1);
         end else begin
            for (i = 0; i < n; i++) note(STAT_LINE, line_mem[i], 1'b0, i + 1 == n);
         end
      end else if (is_back) begin
         seq_count = 0;
         cont_left = 0;
         if (line_len > 0) begin
            i = line_len - 1;
            while (i > 0 && (line_mem[i] & CONT_MASK) == CONT_LOW) i--;
            line_len = i;
            if (line_pts > 0) line_pts--;
         end
         note(STAT_TAKEN, 8'd0, 1'b0, 1'b1);
      end else begin
         if (cont_left > 0) begin
            if (plain && w.key >= CONT_LOW && w.key <= CONT_HIGH && seq_count < 4) begin
               seq_bytes[seq_count] = w.key;
               seq_count++;
               cont_left--;
               if (cont_left == 0) begin
                  if (line_len + seq_count < LINE_BYTES) begin
                     for (i = 0; i < seq_count; i++) begin
                        line_mem[line_len] = seq_bytes[i];
                        line_len++;
                     end
                     line_pts++;
                  end else begin
                     dropped_seqs++;
                  end
                  seq_count = 0;
               end
               note(STAT_TAKEN, 8'd0, 1'b0, 1'b1);
               done = 1'b1;
            end else begin
               seq_count = 0;
               cont_left = 0;
            end
         end
         if (!done) begin
            if (plain && w.key >= CONT_LOW) begin
               if (w.key >= LEAD2_LOW && w.key < LEAD3_LOW) total = 2;
               else if (w.key >= LEAD3_LOW && w.key < LEAD4_LOW) total = 3;
               else if (w.key >= LEAD4_LOW && w.key < LEAD_END) total = 4;
               else total = 0;
               if (total > 1) begin
                  seq_bytes[0] = w.key;
                  seq_count = 1;
                  cont_left = total - 1;
                  note(STAT_TAKEN, 8'd0, 1'b0, 1'b1);
               end else begin
                  note(STAT_IGNORED, 8'd0, 1'b0, 1'b1);
               end
            end else if (plain && w.key >= KEY_SPACE && w.key <= KEY_TILDE) begin
               if (line_len < LINE_BYTES - 1) begin
                  line_mem[line_len] = w.key;
                  line_len++;
                  line_pts++;
                  note(STAT_TAKEN, 8'd0, 1'b0, 1'b1);
               end else begin
                  full_rejects++;
                  note(STAT_IGNORED, 8'd0, 1'b0, 1'b1);
               end
            end else begin
               note(STAT_IGNORED, 8'd0, 1'b0, 1'b1);
            end
         end
      end
   endtask

   task automatic queue_key(input kind_type k, input logic [7:0] b);
      key_word_type w;
      w.kind = k;
      w.key  = b;
      key_queue.push_back(w);
   endtask

   task automatic queue_char();
      queue_key(KIND_BYTE, 8'($urandom_range(KEY_SPACE, KEY_TILDE)));
   endtask

   task automatic queue_lead(input int unsigned total);
      if (total == 2) queue_key(KIND_BYTE, 8'($urandom_range(LEAD2_LOW, LEAD3_LOW - 1)));
      else if (total == 3) queue_key(KIND_BYTE, 8'($urandom_range(LEAD3_LOW, LEAD4_LOW - 1)));
      else queue_key(KIND_BYTE, 8'($urandom_range(LEAD4_LOW, LEAD_END - 1)));
   endtask

   task automatic queue_cont(input int unsigned n);
      repeat (n) queue_key(KIND_BYTE, 8'($urandom_range(CONT_LOW, CONT_HIGH)));
   endtask

   task automatic queue_enter();
      case ($urandom_range(0, 2))
         0: begin
            queue_key(KIND_ENTER, 8'($urandom_range(0, 255)));
         end
         1: begin
            queue_key(KIND_BYTE, KEY_LF);
         end
         default: begin
            queue_key(KIND_BYTE, KEY_CR);
         end
      endcase
   endtask

   task automatic queue_back();
      if ($urandom_range(0, 1) == 0) queue_key(KIND_BACK, 8'($urandom_range(0, 255)));
      else queue_key(KIND_BYTE, KEY_DEL);
   endtask

   task automatic queue_interrupt();
      case ($urandom_range(0, 3))
         0: begin
            queue_key(KIND_FUNC, 8'($urandom_range(0, 255)));
         end
         1: begin
            queue_char();
         end
         2: begin
            queue_key(KIND_BYTE, 8'($urandom_range(0, CONT_LOW - 1)));
         end
         default: begin
            queue_key(KIND_BYTE, 8'($urandom_range(CONT_MASK, 255)));
         end
      endcase
   endtask

   task automatic plan_keys();
      int unsigned steps, total, r;
      queue_key(KIND_FUNC, 8'hFF);
      queue_key(KIND_BACK, 8'h00);
      queue_key(KIND_ENTER, 8'h55);
      queue_key(KIND_BYTE, KEY_SPACE);
      queue_key(KIND_BYTE, KEY_TILDE);
      queue_key(KIND_BYTE, 8'h1F);
      queue_key(KIND_BYTE, 8'h00);
      queue_key(KIND_BYTE, CONT_LOW);
      queue_key(KIND_BYTE, CONT_MASK);
      queue_key(KIND_BYTE, LEAD2_LOW - 8'd1);
      queue_key(KIND_BYTE, LEAD_END);
      queue_key(KIND_BYTE, 8'hFF);
      queue_key(KIND_BYTE, LEAD2_LOW);
      queue_key(KIND_BYTE, CONT_LOW);
      queue_key(KIND_BYTE, LEAD4_LOW - 8'd1);
      queue_key(KIND_BYTE, CONT_HIGH);
      queue_key(KIND_BYTE, CONT_HIGH);
      queue_key(KIND_BYTE, LEAD_END - 8'd1);
      queue_key(KIND_BYTE, CONT_HIGH);
      queue_key(KIND_BYTE, CONT_LOW);
      queue_key(KIND_BYTE, 8'hAA);
      queue_key(KIND_BYTE, LEAD3_LOW);
      queue_key(KIND_BYTE, 8'h41);
      queue_key(KIND_BYTE, LEAD3_LOW - 8'd1);
      queue_key(KIND_FUNC, 8'h00);
      queue_key(KIND_BYTE, KEY_DEL);
      queue_key(KIND_BACK, 8'h5A);
      queue_key(KIND_BYTE, KEY_LF);
      queue_key(KIND_BYTE, 8'h78);
      queue_key(KIND_BYTE, KEY_CR);

      while (key_queue.size() < KEY_TARGET) begin
         if ($urandom_range(0, 5) == 0) steps = $urandom_range(60, 80);
         else steps = $urandom_range(0, 12);
         repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               queue_char();
            end else if (r < 75) begin
               total = $urandom_range(2, 4);
               queue_lead(total);
               queue_cont(total - 1);
            end else if (r < 82) begin
               queue_back();
            end else if (r < 88) begin
               total = $urandom_range(2, 4);
               queue_lead(total);
               queue_cont($urandom_range(0, total - 2));
               queue_interrupt();
            end else if (r < 96) begin
               if ($urandom_range(0, 3) == 0) queue_key(KIND_FUNC, 8'($urandom_range(0, 255)));
               else queue_key(KIND_BYTE, 8'($urandom_range(0, 255)));
            end else begin
               queue_enter();
            end
         end
         queue_enter();
      end
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || keys_sent == keys_driven)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (key_queue.size() > 0) begin
            next_key = key_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_key.key;
            req_tuser  <= next_key.kind;
            keys_driven++;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) hold_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            edit_line(key_word_type'({kind_type'(req_tuser), req_tdata}));
            keys_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_words.size() == 0) begin
               flag_mismatch("word with nothing awaited", 32'(rsp_tdata), 0);
            end else begin
               got_word = awaited_words.pop_front();
               if (rsp_tuser[1:0] !== got_word.status)
                  flag_mismatch("status", 32'(rsp_tuser[1:0]), 32'(got_word.status));
               if (rsp_tdata[7:0] !== got_word.line_char)
                  flag_mismatch("line byte", 32'(rsp_tdata[7:0]), 32'(got_word.line_char));
               if (rsp_tuser[2] !== got_word.empty_flag)
                  flag_mismatch("empty line flag", 32'(rsp_tuser[2]),
                                32'(got_word.empty_flag));
               if (rsp_tlast !== got_word.last_flag)
                  flag_mismatch("tlast", 32'(rsp_tlast), 32'(got_word.last_flag));
               if (rsp_tdata[13:8] !== got_word.len)
                  flag_mismatch("line length", 32'(rsp_tdata[13:8]), 32'(got_word.len));
               if (rsp_tdata[19:14] !== got_word.pts)
                  flag_mismatch("character count", 32'(rsp_tdata[19:14]), 32'(got_word.pts));
               if (rsp_tdata[23:20] !== 4'd0)
                  flag_mismatch("padding", 32'(rsp_tdata[23:20]), 0);
            end
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words still awaited",
                  cycles, awaited_words.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      plan_keys();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (key_queue.size() != 0 || req_tvalid || awaited_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_words.size() != 0)
         flag_mismatch("words never delivered", 0, awaited_words.size());
      $display("Sent %0d key words and checked %0d result words over %0d submitted lines.",
               keys_sent, checked, lines_done);
      $display("Longest line %0d bytes; %0d sequences dropped for lack of room, %0d refused.",
               longest_line, dropped_seqs, full_rejects);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
